### hdl/spc_pkg.sv
// shared types, constants and helpers for the sprite pixel collision unit
// no dependencies; imported by every module of the block
`default_nettype none

package spc_pkg;

    // sprite and screen geometry
    localparam int SPRITE_SIDE = 64;
    localparam int SIDE_W      = $clog2(SPRITE_SIDE);
    localparam int SIZE_W      = SIDE_W + 1;
    localparam int SCREEN_SIDE = 1024;
    localparam int POS_W       = $clog2(SCREEN_SIDE);
    localparam int EXT_W       = POS_W + 1;
    localparam int COLOR_W     = 24;
    localparam logic [COLOR_W-1:0] CLEAR_COLOR = 24'hFFFFFF;

    // request codes
    localparam logic [1:0] REQ_LOAD_OWN    = 2'd0;
    localparam logic [1:0] REQ_LOAD_TARGET = 2'd1;
    localparam logic [1:0] REQ_CHECK       = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_HEIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(SPRITE_SIDE);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOX,
        ST_CLIP,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // row compare control from sequencer to row unit
    typedef struct packed {
        logic              clear;
        logic              valid;
        logic [SIDE_W-1:0] own_shift;
        logic [SIDE_W-1:0] target_shift;
        logic [SIZE_W-1:0] span;
    } row_ctl_t;

    // saturate a configured side to the largest sprite side
    function automatic logic [SIZE_W-1:0] side_limit(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = (v > SIZE_W'(SPRITE_SIDE)) ? SIZE_W'(SPRITE_SIDE) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/spc_mask_ram.sv
// opacity mask memory: one bit written per load, one full row read per cycle
// depends on spc_pkg
`default_nettype none

module spc_mask_ram (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [spc_pkg::SIDE_W-1:0]        wr_row,
    input  wire logic [spc_pkg::SIDE_W-1:0]        wr_col,
    input  wire logic                              wr_bit,
    input  wire logic [spc_pkg::SIDE_W-1:0]        rd_row,
    output logic      [spc_pkg::SPRITE_SIDE-1:0]   rd_data
);
    import spc_pkg::*;

    logic [SPRITE_SIDE-1:0] mem [SPRITE_SIDE];

    // bit write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_row][wr_col] <= wr_bit;
        end
    end

    // registered row read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_row];
    end

endmodule

`default_nettype wire

### hdl/spc_row_unit.sv
// shared row compare unit: aligns two mask rows, ands them over the overlap
// span and accumulates a hit flag; depends on spc_pkg
`default_nettype none

module spc_row_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire spc_pkg::row_ctl_t                 ctl,
    input  wire logic [spc_pkg::SPRITE_SIDE-1:0]   own_row,
    input  wire logic [spc_pkg::SPRITE_SIDE-1:0]   target_row,
    output logic                                   hit
);
    import spc_pkg::*;

    logic                   hit_reg;
    logic                   hit_next;
    logic [SPRITE_SIDE-1:0] span_mask;
    logic [SPRITE_SIDE-1:0] both;

    // overlap span mask, lowest span bits set
    always_comb
    begin
        for (int i = 0; i < SPRITE_SIDE; i++)
        begin
            span_mask[i] = (SIZE_W'(i) < ctl.span);
        end
    end

    // align both rows to the left edge of the shared rectangle
    assign both = (own_row >> ctl.own_shift) & (target_row >> ctl.target_shift) & span_mask;

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.clear)
        begin
            hit_next = 1'b0;
        end
        else if (ctl.valid && (|both))
        begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

### hdl/sprite_pixel_collision_unit.sv
// Sprite pixel collision unit. A load item (own or target) writes one opacity
// bit; white is transparent. A check item passes the box and clip states for
// the box test, then scans one screen row of the shared rectangle per cycle
// (at most 64 rows, none when the boxes do not meet), then the drain state
// empties the row pipeline and the done state posts the result; when the boxes
// do not meet, the clip state goes straight to the done state. The result
// waits in the done state while out_stall holds the previous one, and the unit
// returns to idle before the next item is taken. The row rate is set by
// the single row read port of each mask memory feeding one shared row compare
// unit. in_stall is high for the whole check. Mask memories are not cleared;
// a pixel must be loaded before a check reads it. Depends on spc_pkg,
// spc_mask_ram and spc_row_unit.
`default_nettype none

module sprite_pixel_collision_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [spc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [spc_pkg::SIZE_W-1:0]        cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        req_type,
    input  wire logic [spc_pkg::SIDE_W-1:0]        pixel_row,
    input  wire logic [spc_pkg::SIDE_W-1:0]        pixel_col,
    input  wire logic [spc_pkg::COLOR_W-1:0]       pixel_color,
    input  wire logic [spc_pkg::POS_W-1:0]         own_row,
    input  wire logic [spc_pkg::POS_W-1:0]         own_col,
    input  wire logic [spc_pkg::POS_W-1:0]         target_row,
    input  wire logic [spc_pkg::POS_W-1:0]         target_col,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   boxes_overlap,
    output logic                                   collided
);
    import spc_pkg::*;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] own_h_reg, own_w_reg, tgt_h_reg, tgt_w_reg;

    logic [POS_W-1:0]  orow_reg, ocol_reg, trow_reg, tcol_reg;
    logic [POS_W-1:0]  top_reg, top_next, left_reg, left_next;
    logic [EXT_W-1:0]  bot_reg, bot_next, right_reg, right_next;
    logic [EXT_W-1:0]  row_reg, row_next;
    logic              ovl_reg, ovl_next;
    logic [SIDE_W-1:0] oshift_reg, oshift_next, tshift_reg, tshift_next;
    logic [SIZE_W-1:0] span_reg, span_next;
    logic              rd_valid_reg, rd_valid_next;

    logic              out_valid_reg, out_valid_next;
    logic              boxes_reg, boxes_next;
    logic              coll_reg, coll_next;

    logic              in_xfer;
    logic              out_xfer;
    logic              load_own, load_tgt;
    logic              opaque;
    logic              row_clear;

    logic [SIZE_W-1:0] oh, ow, th, tw;
    logic [EXT_W-1:0]  own_bot, tgt_bot, own_right, tgt_right;
    logic [EXT_W-1:0]  bot_clip, right_clip, own_off, tgt_off;

    logic [SPRITE_SIDE-1:0] own_data, tgt_data;
    row_ctl_t               row_ctl;
    logic                   row_hit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_h_reg <= SIZE_RESET;
            own_w_reg <= SIZE_RESET;
            tgt_h_reg <= SIZE_RESET;
            tgt_w_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OWN_HEIGHT:    own_h_reg <= cfg_data;
                CFG_OWN_WIDTH:     own_w_reg <= cfg_data;
                CFG_TARGET_HEIGHT: tgt_h_reg <= cfg_data;
                CFG_TARGET_WIDTH:  tgt_w_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // pixel loads
    assign opaque   = (pixel_color != CLEAR_COLOR);
    assign load_own = in_xfer && (req_type == REQ_LOAD_OWN);
    assign load_tgt = in_xfer && (req_type == REQ_LOAD_TARGET);

    // mask row read addresses, relative to each sprite's top row
    assign own_off = row_reg - EXT_W'(orow_reg);
    assign tgt_off = row_reg - EXT_W'(trow_reg);

    spc_mask_ram u_own_mask (
        .clk     (clk),
        .we      (load_own),
        .wr_row  (pixel_row),
        .wr_col  (pixel_col),
        .wr_bit  (opaque),
        .rd_row  (own_off[SIDE_W-1:0]),
        .rd_data (own_data)
    );

    spc_mask_ram u_target_mask (
        .clk     (clk),
        .we      (load_tgt),
        .wr_row  (pixel_row),
        .wr_col  (pixel_col),
        .wr_bit  (opaque),
        .rd_row  (tgt_off[SIDE_W-1:0]),
        .rd_data (tgt_data)
    );

    assign row_clear = (state_reg == ST_CLIP);

    assign row_ctl = '{
        clear:        row_clear,
        valid:        rd_valid_reg,
        own_shift:    oshift_reg,
        target_shift: tshift_reg,
        span:         span_reg
    };

    spc_row_unit u_row_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (row_ctl),
        .own_row    (own_data),
        .target_row (tgt_data),
        .hit        (row_hit)
    );

    // box extents
    assign oh        = side_limit(own_h_reg);
    assign ow        = side_limit(own_w_reg);
    assign th        = side_limit(tgt_h_reg);
    assign tw        = side_limit(tgt_w_reg);
    assign own_bot   = EXT_W'(orow_reg) + EXT_W'(oh);
    assign tgt_bot   = EXT_W'(trow_reg) + EXT_W'(th);
    assign own_right = EXT_W'(ocol_reg) + EXT_W'(ow);
    assign tgt_right = EXT_W'(tcol_reg) + EXT_W'(tw);

    // clip the shared rectangle to the screen
    assign bot_clip   = (bot_reg > EXT_W'(SCREEN_SIDE)) ? EXT_W'(SCREEN_SIDE) : bot_reg;
    assign right_clip = (right_reg > EXT_W'(SCREEN_SIDE)) ? EXT_W'(SCREEN_SIDE) : right_reg;

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sequencer datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            orow_reg <= own_row;
            ocol_reg <= own_col;
            trow_reg <= target_row;
            tcol_reg <= target_col;
        end
        top_reg    <= top_next;
        left_reg   <= left_next;
        bot_reg    <= bot_next;
        right_reg  <= right_next;
        row_reg    <= row_next;
        ovl_reg    <= ovl_next;
        oshift_reg <= oshift_next;
        tshift_reg <= tshift_next;
        span_reg   <= span_next;
        boxes_reg  <= boxes_next;
        coll_reg   <= coll_next;
    end

    // sequencer next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        left_next      = left_reg;
        bot_next       = bot_reg;
        right_next     = right_reg;
        row_next       = row_reg;
        ovl_next       = ovl_reg;
        oshift_next    = oshift_reg;
        tshift_next    = tshift_reg;
        span_next      = span_reg;
        rd_valid_next  = 1'b0;
        boxes_next     = boxes_reg;
        coll_next      = coll_reg;
        out_valid_next = out_valid_reg && !out_xfer;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (req_type == REQ_CHECK))
                begin
                    state_next = ST_BOX;
                end
            end
            ST_BOX:
            begin
                top_next   = (orow_reg > trow_reg) ? orow_reg : trow_reg;
                left_next  = (ocol_reg > tcol_reg) ? ocol_reg : tcol_reg;
                bot_next   = (own_bot < tgt_bot) ? own_bot : tgt_bot;
                right_next = (own_right < tgt_right) ? own_right : tgt_right;
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                ovl_next    = (EXT_W'(top_reg) < bot_reg) && (EXT_W'(left_reg) < right_reg);
                bot_next    = bot_clip;
                row_next    = EXT_W'(top_reg);
                oshift_next = SIDE_W'(left_reg - ocol_reg);
                tshift_next = SIDE_W'(left_reg - tcol_reg);
                span_next   = SIZE_W'(right_clip - EXT_W'(left_reg));
                state_next  = ovl_next ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                // one shared-rectangle row per cycle
                rd_valid_next = 1'b1;
                row_next      = row_reg + EXT_W'(1);
                if (row_next >= bot_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // post result once the output register is free
                if (!out_valid_reg || out_xfer)
                begin
                    boxes_next     = ovl_reg;
                    coll_next      = ovl_reg && row_hit;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign boxes_overlap = boxes_reg;
    assign collided      = coll_reg;

    // checks
    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result posted outside done state");

    a_hit_needs_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!coll_reg || boxes_reg))
        else $error("collision reported without box overlap");

    a_scan_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (row_reg < bot_reg))
        else $error("scan row past shared rectangle");

    a_scan_in_own: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |->
            ((own_off < EXT_W'(SPRITE_SIDE)) && (tgt_off < EXT_W'(SPRITE_SIDE))))
        else $error("scan row outside a sprite");

    a_row_valid_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_SCAN))
        else $error("row compare without a scan read");

endmodule

`default_nettype wire
